FILE: rtl/cross_correlation_lags_defines.svh
// Assertion macros used by the checker file of this block.
`ifndef CROSS_CORRELATION_LAGS_DEFINES_SVH
`define CROSS_CORRELATION_LAGS_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define XCL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define XCL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/xcl_pkg.sv
package xcl_pkg;

    localparam int XCL_DATA_W = 16;
    localparam int XCL_PROD_W = 2 * XCL_DATA_W;
    localparam int XCL_ACC_W = 48;
    localparam int XCL_LAG_W = 5;
    localparam int XCL_MAX_LAGS_DEF = 32;
    localparam logic [XCL_LAG_W-1:0] XCL_MAX_LAG_RST = XCL_LAG_W'(15);

    // Control broadcast from the sequencer to every MAC cell.
    typedef struct packed {
        logic load;     // a sample pair is taken: shift x, register the product
        logic mac;      // add the registered product into the accumulator
        logic shift;    // move accumulators one cell toward lag zero
        logic clear;    // frame done: zero taps and accumulators
    } xcl_cell_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_FLUSH = 3'b010,
        ST_DRAIN = 3'b100
    } xcl_state_t;

endpackage

FILE: rtl/cross_correlation_lags.sv
// Output: after the request flagged last is accepted, the block passes the flush state
// and shows lag 0 in the first drain state; the remaining lags follow one per cycle.
// Throughput: one sample pair per cycle inside a frame, set by one MAC cell per lag;
// busy stays high in the flush and drain states while the results drain through the chain.
// Reset: rst_n is asynchronous, active low; it zeroes taps and accumulators, sets max_lag
// to 15 and returns to idle. The receiver cannot stall: each result shows for one cycle.
module cross_correlation_lags #(
    parameter int MAX_LAGS = xcl_pkg::XCL_MAX_LAGS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [xcl_pkg::XCL_DATA_W-1:0] x_sample,
    input  logic signed [xcl_pkg::XCL_DATA_W-1:0] y_sample,
    input  logic                                  last_sample,
    input  logic                                  cfg_we,
    input  logic [xcl_pkg::XCL_LAG_W-1:0]         cfg_wdata,
    output logic                                  result_valid,
    output logic [xcl_pkg::XCL_LAG_W-1:0]         lag_index,
    output logic signed [xcl_pkg::XCL_ACC_W-1:0]  correlation,
    output logic                                  last_lag
);
    import xcl_pkg::*;

    // Highest lag that can be reported: bounded by the chain length and by the
    // width of the lag index.
    localparam int TOP_MAX = (MAX_LAGS - 1 > (2 ** XCL_LAG_W) - 1) ?
                             (2 ** XCL_LAG_W) - 1 : MAX_LAGS - 1;

    xcl_state_t           state_reg, state_next;
    logic                 prod_valid_reg;
    logic [XCL_LAG_W-1:0] max_lag_reg;
    logic [XCL_LAG_W-1:0] top_reg, top_next;
    logic [XCL_LAG_W-1:0] cnt_reg, cnt_next;
    logic                 accept;
    logic                 at_top;
    xcl_cell_ctrl_t       ctrl;

    // x_link[k] feeds cell k; cell k hands its tap on to x_link[k+1].
    logic signed [XCL_DATA_W-1:0] x_link [0:MAX_LAGS];
    // acc_link[k] is the accumulator of cell k; it drains toward cell 0.
    logic signed [XCL_ACC_W-1:0]  acc_link [0:MAX_LAGS];

    // A request is taken whenever the block is idle; the strobe marks drain cycles.
    assign busy         = (state_reg != ST_IDLE);
    assign accept       = start && !busy;
    assign at_top       = (cnt_reg == top_reg);
    assign result_valid = (state_reg == ST_DRAIN);
    assign lag_index    = cnt_reg;
    assign correlation  = acc_link[0];
    assign last_lag     = result_valid && at_top;

    // The value of max_lag in force at the last pair picks the reported range.
    always_comb
    begin
        if (max_lag_reg > XCL_LAG_W'(TOP_MAX))
        begin
            top_next = XCL_LAG_W'(TOP_MAX);
        end
        else
        begin
            top_next = max_lag_reg;
        end
    end

    // Sequencer: idle while a frame streams in, then the flush state so the final
    // product lands in its accumulator, then the drain state, which shows the lags in turn.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ctrl.load  = accept;
        ctrl.mac   = prod_valid_reg;
        ctrl.shift = 1'b0;
        ctrl.clear = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && last_sample)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                state_next = ST_DRAIN;
                cnt_next   = '0;
            end
            ST_DRAIN:
            begin
                if (at_top)
                begin
                    // The whole chain is zeroed so the next frame starts clean.
                    state_next = ST_IDLE;
                    ctrl.clear = 1'b1;
                end
                else
                begin
                    cnt_next   = cnt_reg + XCL_LAG_W'(1);
                    ctrl.shift = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                ctrl.clear = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            prod_valid_reg <= 1'b0;
            max_lag_reg    <= XCL_MAX_LAG_RST;
            cnt_reg        <= '0;
            top_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            prod_valid_reg <= accept;
            cnt_reg        <= cnt_next;
            if (cfg_we)
            begin
                max_lag_reg <= cfg_wdata;
            end
            if (accept && last_sample)
            begin
                top_reg <= top_next;
            end
        end
    end

    // The chain of MAC cells: cell k multiplies y by the x delayed by k pairs and holds the sum for lag k.
    assign x_link[0]          = x_sample;
    assign acc_link[MAX_LAGS] = '0;

    for (genvar k = 0; k < MAX_LAGS; k++)
    begin : g_cell
        xcl_mac_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .x_in    (x_link[k]),
            .y_in    (y_sample),
            .acc_in  (acc_link[k+1]),
            .x_out   (x_link[k+1]),
            .acc_out (acc_link[k])
        );
    end

endmodule

FILE: rtl/xcl_mac_cell.sv
module xcl_mac_cell (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  xcl_pkg::xcl_cell_ctrl_t               ctrl,
    input  logic signed [xcl_pkg::XCL_DATA_W-1:0] x_in,
    input  logic signed [xcl_pkg::XCL_DATA_W-1:0] y_in,
    input  logic signed [xcl_pkg::XCL_ACC_W-1:0]  acc_in,
    output logic signed [xcl_pkg::XCL_DATA_W-1:0] x_out,
    output logic signed [xcl_pkg::XCL_ACC_W-1:0]  acc_out
);
    import xcl_pkg::*;

    localparam logic signed [XCL_ACC_W-1:0] ACC_MAX = {1'b0, {(XCL_ACC_W-1){1'b1}}};
    localparam logic signed [XCL_ACC_W-1:0] ACC_MIN = {1'b1, {(XCL_ACC_W-1){1'b0}}};

    logic signed [XCL_DATA_W-1:0] x_tap_reg;
    logic signed [XCL_PROD_W-1:0] prod_reg;
    logic signed [XCL_PROD_W-1:0] prod_next;
    logic signed [XCL_ACC_W-1:0]  acc_reg;
    logic signed [XCL_ACC_W-1:0]  acc_next;
    logic signed [XCL_ACC_W:0]    sum;

    assign prod_next = XCL_PROD_W'(x_in) * XCL_PROD_W'(y_in);
    assign sum = {acc_reg[XCL_ACC_W-1], acc_reg}
               + {{(XCL_ACC_W + 1 - XCL_PROD_W){prod_reg[XCL_PROD_W-1]}}, prod_reg};

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clear)
        begin
            acc_next = '0;
        end
        else if (ctrl.shift)
        begin
            acc_next = acc_in;
        end
        else if (ctrl.mac)
        begin
            // Clamp when the two top bits of the wide sum disagree.
            if (sum[XCL_ACC_W] != sum[XCL_ACC_W-1])
            begin
                acc_next = sum[XCL_ACC_W] ? ACC_MIN : ACC_MAX;
            end
            else
            begin
                acc_next = sum[XCL_ACC_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_tap_reg <= '0;
            acc_reg   <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
            if (ctrl.clear)
            begin
                x_tap_reg <= '0;
            end
            else if (ctrl.load)
            begin
                x_tap_reg <= x_in;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            prod_reg <= prod_next;
        end
    end

    assign x_out   = x_tap_reg;
    assign acc_out = acc_reg;

endmodule

FILE: rtl/xcl_checker.sv
`include "cross_correlation_lags_defines.svh"

module xcl_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  start,
    input logic                                  busy,
    input logic                                  last_sample,
    input logic                                  result_valid,
    input logic [xcl_pkg::XCL_LAG_W-1:0]         lag_index,
    input logic                                  last_lag
);
    import xcl_pkg::*;

    `XCL_ASSERT_SAME(a_result_only_busy, result_valid, busy, "result shown while idle")
    `XCL_ASSERT_NEXT(a_flush_after_last, start && !busy && last_sample,
        busy && !result_valid, "no flush cycle after the last request")
    `XCL_ASSERT_NEXT(a_lags_in_order, result_valid && !last_lag,
        result_valid && (lag_index == $past(lag_index) + XCL_LAG_W'(1)), "lag order broken")
    `XCL_ASSERT_NEXT(a_idle_after_top, result_valid && last_lag, !busy && !result_valid,
        "block still busy after the highest lag")

endmodule

bind cross_correlation_lags xcl_checker u_xcl_checker (.*);
